### design/acrw_pkg.sv
// shared types and constants for the audio capture ring writer
package acrw_pkg;

    localparam int ADDR_W = 5;
    localparam int SIZE_W = 27;
    localparam int RAW_W  = 24;
    localparam int RDOFF_W = 26;

    localparam logic [2:0] REG_RECORDING_ON = 3'd0;
    localparam logic [2:0] REG_RECORD_24BIT = 3'd1;
    localparam logic [2:0] REG_GAIN_Q12     = 3'd2;
    localparam logic [2:0] REG_BUFFER_BASE  = 3'd3;
    localparam logic [2:0] REG_BUFFER_SIZE  = 3'd4;

    localparam logic [15:0]       GAIN_RESET = 16'd3686;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 27'd67108864;

    typedef struct packed {
        logic              recording_on;
        logic              record_24bit;
        logic [15:0]       gain_q12;
        logic [31:0]       buffer_base;
        logic [SIZE_W-1:0] buffer_size;
    } t_cfg;

    typedef struct packed {
        logic restart;
        logic last_in_block;
    } t_frame_flags;

endpackage

### design/acrw_front.sv
// front end: frame intake, gain multiply, truncation and saturation
module acrw_front import acrw_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int OFFSET_BITS = 26
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [RAW_W-1:0]       i_codec_slot0,
    input  logic [RAW_W-1:0]       i_codec_slot1,
    input  logic                   i_last_in_block,
    input  logic [RDOFF_W-1:0]     i_read_offset,
    input  logic                   i_restart,
    output logic                   o_push,
    input  logic                   i_q_ready,
    output logic [((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24)-1:0] o_s1,
    output logic [((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24)-1:0] o_s0,
    output logic [OFFSET_BITS-1:0] o_rd,
    output t_frame_flags           o_flags
);

    localparam int VW = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
    localparam int PW = RAW_W + 17;
    localparam int QW = PW - 12;
    localparam int CW = ((QW > SAMPLE_BITS) ? QW : SAMPLE_BITS) + 1;
    localparam longint SAT_HI_L = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam logic signed [CW-1:0] SAT_HI = CW'(SAT_HI_L);
    localparam logic signed [CW-1:0] SAT_LO = -SAT_HI - CW'(1);

    logic                   r_v1;
    logic [RAW_W-1:0]       r_slot0;
    logic [RAW_W-1:0]       r_slot1;
    logic [OFFSET_BITS-1:0] r_rd1;
    t_frame_flags           r_flags1;

    logic                   r_v2;
    logic signed [PW-1:0]   r_p0;
    logic signed [PW-1:0]   r_p1;
    logic [OFFSET_BITS-1:0] r_rd2;
    t_frame_flags           r_flags2;

    logic adv1;
    logic adv2;

    function automatic logic [VW-1:0] f_scale(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] pr;
        logic signed [QW-1:0] q;
        logic signed [CW-1:0] qx;
        pr = p + (p[PW-1] ? PW'(4095) : PW'(0));
        q  = pr[PW-1:12];
        qx = CW'(q);
        if (qx > SAT_HI) begin
            qx = SAT_HI;
        end else if (qx < SAT_LO) begin
            qx = SAT_LO;
        end
        return qx[VW-1:0];
    endfunction

    assign adv2    = r_v2 && i_q_ready;
    assign adv1    = r_v1 && (!r_v2 || adv2);
    assign o_ready = !r_v1 || adv1;
    assign o_push  = adv2;
    assign o_s1    = f_scale(r_p1);
    assign o_s0    = f_scale(r_p0);
    assign o_rd    = r_rd2;
    assign o_flags = r_flags2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (adv2) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_slot0                <= i_codec_slot0;
            r_slot1                <= i_codec_slot1;
            r_rd1                  <= OFFSET_BITS'(i_read_offset);
            r_flags1.restart       <= i_restart;
            r_flags1.last_in_block <= i_last_in_block;
        end
        if (adv1) begin
            r_p0     <= $signed(r_slot0) * $signed({1'b0, i_cfg.gain_q12});
            r_p1     <= $signed(r_slot1) * $signed({1'b0, i_cfg.gain_q12});
            r_rd2    <= r_rd1;
            r_flags2 <= r_flags1;
        end
    end

endmodule

### design/acrw_queue.sv
// two-entry fifo between front and back
module acrw_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_pop,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

### design/acrw_back.sv
// back end: write sequencer, ring offset and output register
module acrw_back import acrw_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int OFFSET_BITS = 26
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_valid,
    output logic                   o_q_pop,
    input  logic [((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24)-1:0] i_s1,
    input  logic [((SAMPLE_BITS > 24) ? SAMPLE_BITS : 24)-1:0] i_s0,
    input  logic [OFFSET_BITS-1:0] i_rd,
    input  t_frame_flags           i_flags,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [31:0]            o_write_address,
    output logic [15:0]            o_write_data,
    output logic                   o_write_two_bytes,
    output logic                   o_last_of_frame,
    output logic                   o_overrun
);

    localparam int VW = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
    localparam int AW = ((OFFSET_BITS > SIZE_W) ? OFFSET_BITS : SIZE_W) + 1;
    localparam logic [2:0] LAST_24 = 3'd5;
    localparam logic [2:0] LAST_16 = 3'd1;

    logic                   r_busy;
    logic [2:0]             r_cnt;
    logic [VW-1:0]          r_s1;
    logic [VW-1:0]          r_s0;
    logic [OFFSET_BITS-1:0] r_rd;
    logic                   r_lib;
    logic [OFFSET_BITS-1:0] r_wo;
    logic [OFFSET_BITS-1:0] n_wo;

    logic                   r_ov;
    logic [31:0]            r_addr;
    logic [15:0]            r_data;
    logic                   r_two;
    logic                   r_last;
    logic                   r_overrun;

    logic                   emit;
    logic                   is_last;
    logic                   load;
    logic [2:0]             last_idx;
    logic [VW-1:0]          cur;
    logic [7:0]             cur_byte;
    logic [15:0]            data;
    logic [OFFSET_BITS-1:0] wo_adv;

    function automatic logic [OFFSET_BITS-1:0] f_adv(
        input logic [OFFSET_BITS-1:0] wo,
        input logic                   two,
        input logic [SIZE_W-1:0]      size
    );
        logic [AW-1:0] nx;
        nx = AW'(wo) + (two ? AW'(2) : AW'(1));
        if (nx >= AW'(size)) begin
            nx = nx - AW'(size);
            if (nx >= AW'(size)) begin
                nx = '0;
            end
        end
        return nx[OFFSET_BITS-1:0];
    endfunction

    assign last_idx = i_cfg.record_24bit ? LAST_24 : LAST_16;
    assign emit     = r_busy && (!r_ov || i_ready);
    assign is_last  = (r_cnt == last_idx);
    assign load     = i_q_valid && (!r_busy || (emit && is_last));
    assign o_q_pop  = load;
    assign wo_adv   = f_adv(r_wo, !i_cfg.record_24bit, i_cfg.buffer_size);

    always_comb begin
        if (i_cfg.record_24bit) begin
            cur = (r_cnt < 3'd3) ? r_s1 : r_s0;
        end else begin
            cur = (r_cnt == 3'd0) ? r_s1 : r_s0;
        end
        case (r_cnt)
            3'd1, 3'd4: cur_byte = cur[15:8];
            3'd2, 3'd5: cur_byte = cur[23:16];
            default:    cur_byte = cur[7:0];
        endcase
        if (i_cfg.record_24bit) begin
            data = {8'h00, cur_byte};
        end else begin
            data = cur[SAMPLE_BITS-1 -: 16];
        end
        n_wo = r_wo;
        if (emit) begin
            n_wo = wo_adv;
        end
        if (load && i_flags.restart) begin
            n_wo = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_wo   <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_wo <= n_wo;
            if (load) begin
                r_busy <= i_cfg.recording_on;
                r_cnt  <= 3'd0;
            end else if (emit) begin
                r_busy <= !is_last;
                r_cnt  <= r_cnt + 3'd1;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1  <= i_s1;
            r_s0  <= i_s0;
            r_rd  <= i_rd;
            r_lib <= i_flags.last_in_block;
        end
        if (emit) begin
            r_addr    <= i_cfg.buffer_base + 32'(r_wo);
            r_data    <= data;
            r_two     <= !i_cfg.record_24bit;
            r_last    <= is_last;
            r_overrun <= is_last && (wo_adv == r_rd) && !r_lib;
        end
    end

    assign o_valid           = r_ov;
    assign o_write_address   = r_addr;
    assign o_write_data      = r_data;
    assign o_write_two_bytes = r_two;
    assign o_last_of_frame   = r_last;
    assign o_overrun         = r_overrun;

endmodule

### design/audio_capture_ring_writer.sv
// top level: config registers, front end, frame queue and write sequencer
// path: front input and product regs, queue, back sample and output registers
// writes: six per frame in 24-bit mode, two in 16-bit mode, one per cycle while
// the output is not stalled; a frame with recording off makes no writes
// reset: synchronous, presets config, clears control state, write offset at once
module audio_capture_ring_writer import acrw_pkg::*; #(
    parameter int SAMPLE_BITS = 24,
    parameter int OFFSET_BITS = 26
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [RAW_W-1:0]   i_codec_slot0,
    input  logic [RAW_W-1:0]   i_codec_slot1,
    input  logic               i_last_in_block,
    input  logic [RDOFF_W-1:0] i_read_offset,
    input  logic               i_restart,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [31:0]        o_write_address,
    output logic [15:0]        o_write_data,
    output logic               o_write_two_bytes,
    output logic               o_last_of_frame,
    output logic               o_overrun
);

    localparam int VW = (SAMPLE_BITS > 24) ? SAMPLE_BITS : 24;
    localparam int QW = 2 + 2 * VW + OFFSET_BITS;

    t_cfg                   r_cfg;
    logic [2:0]             reg_idx;

    logic                   f_push;
    logic                   q_ready;
    logic [VW-1:0]          f_s1;
    logic [VW-1:0]          f_s0;
    logic [OFFSET_BITS-1:0] f_rd;
    t_frame_flags           f_flags;

    logic                   q_valid;
    logic                   q_pop;
    logic [QW-1:0]          q_out;
    logic [VW-1:0]          b_s1;
    logic [VW-1:0]          b_s0;
    logic [OFFSET_BITS-1:0] b_rd;
    t_frame_flags           b_flags;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.recording_on <= 1'b0;
            r_cfg.record_24bit <= 1'b0;
            r_cfg.gain_q12     <= GAIN_RESET;
            r_cfg.buffer_base  <= 32'd0;
            r_cfg.buffer_size  <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                REG_RECORDING_ON: r_cfg.recording_on <= pwdata[0];
                REG_RECORD_24BIT: r_cfg.record_24bit <= pwdata[0];
                REG_GAIN_Q12:     r_cfg.gain_q12     <= pwdata[15:0];
                REG_BUFFER_BASE:  r_cfg.buffer_base  <= pwdata;
                REG_BUFFER_SIZE:  r_cfg.buffer_size  <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RECORDING_ON: prdata = {31'd0, r_cfg.recording_on};
            REG_RECORD_24BIT: prdata = {31'd0, r_cfg.record_24bit};
            REG_GAIN_Q12:     prdata = {16'd0, r_cfg.gain_q12};
            REG_BUFFER_BASE:  prdata = r_cfg.buffer_base;
            REG_BUFFER_SIZE:  prdata = {5'd0, r_cfg.buffer_size};
            default:          prdata = 32'd0;
        endcase
    end

    acrw_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_codec_slot0   (i_codec_slot0),
        .i_codec_slot1   (i_codec_slot1),
        .i_last_in_block (i_last_in_block),
        .i_read_offset   (i_read_offset),
        .i_restart       (i_restart),
        .o_push          (f_push),
        .i_q_ready       (q_ready),
        .o_s1            (f_s1),
        .o_s0            (f_s0),
        .o_rd            (f_rd),
        .o_flags         (f_flags)
    );

    acrw_queue #(
        .W (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .o_ready (q_ready),
        .i_data  ({f_flags, f_s1, f_s0, f_rd}),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_out)
    );

    assign {b_flags, b_s1, b_s0, b_rd} = q_out;

    acrw_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_valid         (q_valid),
        .o_q_pop           (q_pop),
        .i_s1              (b_s1),
        .i_s0              (b_s0),
        .i_rd              (b_rd),
        .i_flags           (b_flags),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_write_address   (o_write_address),
        .o_write_data      (o_write_data),
        .o_write_two_bytes (o_write_two_bytes),
        .o_last_of_frame   (o_last_of_frame),
        .o_overrun         (o_overrun)
    );

endmodule
